[rtl/core/rmsr_pkg.sv]
// Shared constants, types and width helpers of the RMS reduction block.
// No dependencies; every other file of the block imports this package.

package rmsr_pkg;

  // Sample format: signed Q1.15 per component.
  localparam int SAMPLE_BITS = 16;
  // One squared component: magnitude up to 2^15, square up to 2^30.
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
  // Result format: unsigned Q2.15.
  localparam int OUT_BITS    = 17;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_BITS  = 32;
  localparam int OUT_TDATA_BITS = 24;

  // Configuration port.
  localparam int LEN_BITS      = 13;
  localparam int LEN_REG_MAX   = 8191;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_ADDR_BITS-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COMPLEX_MODE  = 1'b1;

  // Default build size.
  localparam int MAX_VECTOR_LENGTH_DEF = 4096;

  // Request queue between the front and back ends.
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [Q_CNT_BITS-1:0] count;
    logic                  nonempty;
  } rmsr_qstat_t;

  // Longest vector the length register can select at a given build size.
  function automatic int len_cap(input int max_len);
    len_cap = (max_len < LEN_REG_MAX) ? max_len : LEN_REG_MAX;
  endfunction

  // Sum width: a complex square needs SQ_BITS+1 bits, times the longest vector.
  function automatic int sum_bits(input int max_len);
    sum_bits = SQ_BITS + 1 + $clog2(len_cap(max_len));
  endfunction

endpackage

[rtl/core/rms_reduction.sv]
// Top level of the RMS reduction block: front end, request queue, back end.
// Depends on rmsr_pkg, rmsr_front, rmsr_queue and rmsr_back.
//
// Usage: program vector_length (index 0) and complex_mode (index 1) on the
// cfg_ port while the block is idle, then stream samples on in_, one per
// request, in reduction order. After every vector_length samples one request
// leaves on out_ carrying floor(sqrt(sum of squares / length)) as Q2.15.
// A length of 0 acts as 1; a length above MAX_VECTOR_LENGTH acts as it.
//
// Throughput: the front end takes one sample per cycle while in_tready is
// high. The back end works on one vector total at a time: a handoff state,
// the serial divider, the square root unit and a handoff state to the
// output register. The queue holds two vector totals, so vectors shorter
// than the back end's run pay the difference as in_tready low.
// The last sample of a vector reaches out_tvalid through the squaring
// register, the queue, the divider, the square root unit and the output register.
// Reset clears the sum, the sample count, the queue and the output register
// and restores length 1, real mode. When the receiver stalls, the result
// holds in the output register, the back end finishes its next vector and
// waits, the queue fills, and then in_tready drops.

module rms_reduction #(
  parameter int MAX_VECTOR_LENGTH = rmsr_pkg::MAX_VECTOR_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_wr_en,
  input  logic [rmsr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [rmsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  // Sample stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rmsr_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // [15:0] sample_re, [31:16] sample_im
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rmsr_pkg::OUT_TDATA_BITS-1:0] out_tdata   // [16:0] rms_value, [23:17] zero
);
  import rmsr_pkg::*;

  localparam int QW = sum_bits(MAX_VECTOR_LENGTH) + LEN_BITS;

  rmsr_qstat_t    q_stat;
  logic           push_valid;
  logic [QW-1:0]  push_data;
  logic           pop;
  logic [QW-1:0]  head_data;

  // Intake, square and accumulate; hands one total per vector to the queue.
  rmsr_front #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Decouple the front end, one sample per cycle while in_tready is high, from the multi-cycle back end.
  rmsr_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_data  (head_data),
    .q_stat     (q_stat)
  );

  // Divide by length, take the root, drive the output register.
  rmsr_back #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_data  (head_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/core/rmsr_front.sv]
// Front end of the RMS reduction: configuration registers, sample intake,
// squaring and accumulation. Depends on rmsr_pkg; feeds rmsr_queue.

module rmsr_front #(
  parameter int MAX_VECTOR_LENGTH = rmsr_pkg::MAX_VECTOR_LENGTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rmsr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [rmsr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [rmsr_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  input  rmsr_pkg::rmsr_qstat_t                 q_stat,
  output logic                                  push_valid,
  output logic [rmsr_pkg::sum_bits(MAX_VECTOR_LENGTH)+rmsr_pkg::LEN_BITS-1:0] push_data
);
  import rmsr_pkg::*;

  localparam int LEN_CAP = len_cap(MAX_VECTOR_LENGTH);
  localparam int CW      = $clog2(LEN_CAP);
  localparam int SUMW    = sum_bits(MAX_VECTOR_LENGTH);

  logic [LEN_BITS-1:0]        len_r;
  logic                       cplx_r;
  logic [LEN_BITS-1:0]        len_eff;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [CW:0]                count_inc;
  logic                       last;
  logic                       accept;
  logic                       a_valid_r;
  logic                       a_last_r;
  logic [SQ_BITS-1:0]         sq_re_r;
  logic [SQ_BITS-1:0]         sq_im_r;
  logic [SUMW-1:0]            sum_r;
  logic [SQ_BITS:0]           sq_sum;
  logic [SUMW-1:0]            sum_add;
  logic signed [SAMPLE_BITS-1:0]   re;
  logic signed [SAMPLE_BITS-1:0]   im;
  logic signed [2*SAMPLE_BITS-1:0] prod_re;
  logic signed [2*SAMPLE_BITS-1:0] prod_im;
  logic [Q_CNT_BITS:0]        q_load;

  // Clamp the programmed length to 1..LEN_CAP.
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_r > LEN_BITS'(LEN_CAP)) begin
      len_eff = LEN_BITS'(LEN_CAP);
    end else begin
      len_eff = len_r;
    end
  end

  assign re      = in_tdata[SAMPLE_BITS-1:0];
  assign im      = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign prod_re = re * re;
  assign prod_im = im * im;

  assign count_inc = {1'b0, count_r} + (CW+1)'(1);
  assign last      = (LEN_BITS+1)'(count_inc) >= {1'b0, len_eff};
  assign count_nxt = last ? '0 : count_inc[CW-1:0];

  // Hold off intake while a vector end in flight could find the queue full.
  assign q_load    = {1'b0, q_stat.count} + {{Q_CNT_BITS{1'b0}}, a_valid_r & a_last_r};
  assign in_tready = q_load < (Q_CNT_BITS+1)'(Q_DEPTH);
  assign accept    = in_tvalid & in_tready;

  assign sq_sum  = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign sum_add = sum_r + SUMW'(sq_sum);

  assign push_valid = a_valid_r & a_last_r;
  assign push_data  = {len_eff, sum_add};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_BITS'(1);
      cplx_r    <= 1'b0;
      count_r   <= '0;
      a_valid_r <= 1'b0;
      a_last_r  <= 1'b0;
      sum_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_VECTOR_LENGTH: len_r  <= cfg_wdata[LEN_BITS-1:0];
          REG_COMPLEX_MODE:  cplx_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      a_valid_r <= accept;
      if (accept) begin
        count_r  <= count_nxt;
        a_last_r <= last;
      end
      // Accumulate; clear at the end of a vector as its total goes out.
      if (a_valid_r) begin
        sum_r <= a_last_r ? '0 : sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_re_r <= prod_re[SQ_BITS-1:0];
      sq_im_r <= cplx_r ? prod_im[SQ_BITS-1:0] : '0;
    end
  end

endmodule

[rtl/core/rmsr_queue.sv]
// Short request queue between the front and back ends of the RMS reduction.
// Depends on rmsr_pkg for depth and status type.

module rmsr_queue #(
  parameter int W = 57
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  logic [W-1:0]          push_data,
  input  logic                  pop,
  output logic [W-1:0]          head_data,
  output rmsr_pkg::rmsr_qstat_t q_stat
);
  import rmsr_pkg::*;

  logic [W-1:0]            mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr_r;
  logic [Q_PTR_BITS-1:0]   rd_ptr_r;
  logic [Q_CNT_BITS-1:0]   count_r;

  assign head_data       = mem[rd_ptr_r];
  assign q_stat.count    = count_r;
  assign q_stat.nonempty = count_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push_valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/rmsr_back.sv]
// Back end of the RMS reduction: bit-serial divide by length, digit-by-digit
// integer square root and the output register. Depends on rmsr_pkg.

module rmsr_back #(
  parameter int MAX_VECTOR_LENGTH = rmsr_pkg::MAX_VECTOR_LENGTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rmsr_pkg::rmsr_qstat_t                 q_stat,
  input  logic [rmsr_pkg::sum_bits(MAX_VECTOR_LENGTH)+rmsr_pkg::LEN_BITS-1:0] head_data,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rmsr_pkg::OUT_TDATA_BITS-1:0]   out_tdata
);
  import rmsr_pkg::*;

  localparam int SUMW  = sum_bits(MAX_VECTOR_LENGTH);
  localparam int SQRTW = SUMW + (SUMW % 2);
  localparam int RTW   = SQRTW / 2;
  localparam int RMW   = RTW + 2;
  localparam int CNTW  = $clog2(SUMW + 1);

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_DIV  = 4'b0010,
    BK_SQRT = 4'b0100,
    BK_DONE = 4'b1000
  } bk_state_t;

  bk_state_t            state_r;
  bk_state_t            state_nxt;
  logic [CNTW-1:0]      cnt_r;
  logic [CNTW-1:0]      cnt_nxt;
  logic                 cnt_last;
  logic                 out_free;
  logic                 out_valid_r;
  logic [OUT_BITS-1:0]  out_data_r;

  logic [LEN_BITS-1:0]  div_r;
  logic [SUMW-1:0]      quo_r;
  logic [LEN_BITS-1:0]  drem_r;
  logic [LEN_BITS:0]    drem_sh;
  logic [LEN_BITS:0]    ddiff;
  logic                 dge;
  logic [LEN_BITS-1:0]  drem_step;
  logic [SUMW-1:0]      quo_step;

  logic [SQRTW-1:0]     rad_r;
  logic [RMW-1:0]       srem_r;
  logic [RTW-1:0]       root_r;
  logic [RMW-1:0]       srem_sh;
  logic [RMW-1:0]       trial;
  logic [RMW-1:0]       sdiff;
  logic                 sge;
  logic [RMW-1:0]       srem_step;
  logic [RTW-1:0]       root_step;

  // Restoring division: one quotient bit per cycle, MSB first.
  assign drem_sh   = {drem_r, quo_r[SUMW-1]};
  assign ddiff     = drem_sh - {1'b0, div_r};
  assign dge       = drem_sh >= {1'b0, div_r};
  assign drem_step = dge ? ddiff[LEN_BITS-1:0] : drem_sh[LEN_BITS-1:0];
  assign quo_step  = {quo_r[SUMW-2:0], dge};

  // Square root: two radicand bits in, one root bit out per cycle.
  assign srem_sh   = {srem_r[RMW-3:0], rad_r[SQRTW-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign sdiff     = srem_sh - trial;
  assign sge       = srem_sh >= trial;
  assign srem_step = sge ? sdiff : srem_sh;
  assign root_step = {root_r[RTW-2:0], sge};

  assign cnt_last  = cnt_r == CNTW'(1);
  assign out_free  = !out_valid_r || out_tready;
  assign pop       = (state_r == BK_IDLE) && q_stat.nonempty;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_BITS'(out_data_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      BK_IDLE: begin
        if (q_stat.nonempty) begin
          state_nxt = BK_DIV;
          cnt_nxt   = CNTW'(SUMW);
        end
      end
      BK_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          state_nxt = BK_SQRT;
          cnt_nxt   = CNTW'(RTW);
        end
      end
      BK_SQRT: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_last) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if ((state_r == BK_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        quo_r  <= head_data[SUMW-1:0];
        div_r  <= head_data[SUMW+LEN_BITS-1:SUMW];
        drem_r <= '0;
      end
      BK_DIV: begin
        quo_r  <= quo_step;
        drem_r <= drem_step;
        rad_r  <= SQRTW'(quo_step);
        srem_r <= '0;
        root_r <= '0;
      end
      BK_SQRT: begin
        rad_r  <= {rad_r[SQRTW-3:0], 2'b00};
        srem_r <= srem_step;
        root_r <= root_step;
      end
      BK_DONE: begin
        if (out_free) begin
          out_data_r <= root_r[OUT_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/rmsr_checker.sv]
// Port-level checks of the RMS reduction block, bound to the top level.
// Depends on rmsr_pkg for port widths.

module rmsr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rmsr_pkg::OUT_TDATA_BITS-1:0] out_tdata
);
  import rmsr_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Padding bits above the result stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_BITS-1:OUT_BITS] == '0)
    else $error("result padding not zero");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the queue, so intake is open right after it.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("intake closed after reset");

endmodule

bind rms_reduction rmsr_checker u_rmsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/tb_rms_reduction.sv]
// Self-checking testbench for rms_reduction: a directed table, then random vectors.
// Depends on rmsr_pkg and the rms_reduction RTL; expected values come from a local predictor.

module tb_rms_reduction;
  import rmsr_pkg::*;

  // Settling time for the back end once every expected result is out, before a
  // register write and at the end of the run.
  localparam int IDLE_WAIT      = 100;
  // Cycles without any request on any port before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_SAMPLES = 700;
  // Length of the closing full-scale complex vector.
  localparam int FINAL_LEN      = 128;
  localparam int EFF_MAX        = MAX_VECTOR_LENGTH_DEF;
  // Predicted rows carry this instead of a hand-typed result.
  localparam int FROM_PREDICTOR = -1;

  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;
  typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } rx_mode_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_ADDR_BITS-1:0]  addr;
    logic [CFG_DATA_BITS-1:0]  value;
    logic [SAMPLE_BITS-1:0]    re;
    logic [SAMPLE_BITS-1:0]    im;
    int                        rms_typed;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata;   // [15:0] sample_re, [31:16] sample_im
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_TDATA_BITS-1:0] out_tdata;  // [16:0] rms_value, [23:17] zero

  // Shadow of the block: registers and accumulator as the predictor sees them.
  logic [LEN_BITS-1:0]       len_shadow;
  logic                      complex_shadow;
  logic [63:0]               square_acc;
  int                        taken;

  logic [OUT_BITS-1:0]       rms_expected_q[$];
  stim_row_t                 directed_rows[$];

  int errors;
  int samples_sent;
  int results_seen;
  int reg_writes;
  int random_sent;
  int idle_cycles;
  int burst_left;
  bit dirty;  // a sample went in since the last drain

  rms_reduction u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Magnitude of a signed Q1.15 component; -1.0 gives 32768.
  function automatic logic [16:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? (17'd65536 - {1'b0, v}) : {1'b0, v};
  endfunction

  // Floor of the square root, built one result bit at a time from the top.
  function automatic logic [31:0] int_sqrt(input logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  // Length 0 acts as 1; anything past the build maximum is clamped to it.
  function automatic int effective_length(input logic [LEN_BITS-1:0] len);
    if (len == 0) return 1;
    if (int'(len) > EFF_MAX) return EFF_MAX;
    return int'(len);
  endfunction

  // Fold one accepted sample into the shadow sum; queue a result when the
  // vector closes. A typed value, where given, replaces the predicted one.
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] re,
                               input logic [SAMPLE_BITS-1:0] im, input int typed);
    logic [16:0] mre;
    logic [16:0] mim;
    logic [63:0] sq;
    logic [31:0] root;
    int          eff;
    eff = effective_length(len_shadow);
    mre = magnitude(re);
    mim = magnitude(im);
    sq  = 64'(mre) * 64'(mre);
    if (complex_shadow) sq += 64'(mim) * 64'(mim);
    square_acc += sq;
    taken++;
    // A length cut below the count mid-vector closes the vector on this sample.
    if (taken >= eff) begin
      root = int_sqrt(square_acc / 64'(eff));
      if (typed == FROM_PREDICTOR) rms_expected_q.push_back(root[OUT_BITS-1:0]);
      else rms_expected_q.push_back(OUT_BITS'(typed));
      square_acc = '0;
      taken      = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers: everything changes at the falling edge; tasks enter and leave there.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
  endtask

  // Hold off the sender until every expected result is out, then let the
  // back end settle.
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left  = 0;
    while (rms_expected_q.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
    dirty = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] value);
    if (dirty) drain_results();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    if (addr == REG_VECTOR_LENGTH) len_shadow = value[LEN_BITS-1:0];
    else if (addr == REG_COMPLEX_MODE) complex_shadow = value[0];
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    // Keep the enable low before returning so a following write never raises it in this step.
    @(negedge clk);
  endtask

  // Send one sample request. Bursts of random length alternate with random
  // gaps; valid stays high across a burst so it is never dropped and raised
  // in one step.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] re,
                             input logic [SAMPLE_BITS-1:0] im, input int typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {im, re};
    do @(posedge clk); while (!in_tready);
    absorb_sample(re, im, typed);
    samples_sent++;
    burst_left--;
    dirty = 1'b1;
    @(negedge clk);
  endtask

  // Sample values weighted toward the edges of Q1.15.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return 16'($signed(9'($urandom_range(0, 511))));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_cfg(input logic [CFG_ADDR_BITS-1:0] addr,
                         input logic [CFG_DATA_BITS-1:0] value);
    stim_row_t row;
    row.kind      = ROW_CFG;
    row.addr      = addr;
    row.value     = value;
    row.re        = '0;
    row.im        = '0;
    row.rms_typed = FROM_PREDICTOR;
    directed_rows.push_back(row);
  endtask

  task automatic add_sample(input logic [SAMPLE_BITS-1:0] re,
                            input logic [SAMPLE_BITS-1:0] im, input int typed);
    stim_row_t row;
    row.kind      = ROW_SAMPLE;
    row.addr      = '0;
    row.value     = '0;
    row.re        = re;
    row.im        = im;
    row.rms_typed = typed;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, switching mode after each random-length run.
  // ---------------------------------------------------------------------------

  initial begin : receiver
    rx_mode_t mode;
    int       left;
    int       tick;
    out_tready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:   out_tready <= ((tick % 9) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog, both on the rising edge.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rms_expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_tdata), 0);
      end else begin
        if (out_tdata[OUT_BITS-1:0] !== rms_expected_q[0])
          report_mismatch("rms_value", 32'(out_tdata[OUT_BITS-1:0]), 32'(rms_expected_q[0]));
        if (out_tdata[OUT_TDATA_BITS-1:OUT_BITS] !== '0)
          report_mismatch("tdata padding", 32'(out_tdata[OUT_TDATA_BITS-1:OUT_BITS]), 0);
        void'(rms_expected_q.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [LEN_BITS-1:0] len;
    int                  eff;
    int                  count;

    // Drive every input to a known value from time zero.
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    len_shadow     = LEN_BITS'(1);
    complex_shadow = 1'b0;
    square_acc     = '0;
    taken          = 0;
    errors         = 0;
    samples_sent   = 0;
    results_seen   = 0;
    reg_writes     = 0;
    random_sent    = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    dirty          = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. Out of reset: length 1, real mode, so each sample is
    // its own vector and the result is |sample_re|.
    add_sample(16'h8000, 16'h0000, 32768);
    add_sample(16'h7FFF, 16'h8000, 32767);  // imaginary part ignored
    add_sample(16'h0000, 16'h7FFF, 0);
    // Complex, single-sample vectors: the magnitude rounded down.
    add_cfg(REG_COMPLEX_MODE, 13'd1);
    add_sample(16'h8000, 16'h8000, 46340);
    add_sample(16'h0000, 16'h8000, 32768);
    add_sample(16'h0003, 16'hFFFC, 5);
    // Zero length behaves as length 1.
    add_cfg(REG_VECTOR_LENGTH, 13'd0);
    add_sample(16'h7FFF, 16'h7FFF, 46339);
    // Four real samples at full scale.
    add_cfg(REG_VECTOR_LENGTH, 13'd4);
    add_cfg(REG_COMPLEX_MODE, 13'd0);
    add_sample(16'h8000, 16'h1234, FROM_PREDICTOR);
    add_sample(16'h8000, 16'h0000, FROM_PREDICTOR);
    add_sample(16'h8000, 16'hFFFF, FROM_PREDICTOR);
    add_sample(16'h8000, 16'h7FFF, 32768);
    // Length shortened below the count mid-vector: the next sample closes it.
    add_cfg(REG_VECTOR_LENGTH, 13'(EFF_MAX));
    add_sample(16'd1000, 16'h0000, FROM_PREDICTOR);
    add_sample(16'hFC18, 16'h0000, FROM_PREDICTOR);
    add_sample(16'd1000, 16'h0000, FROM_PREDICTOR);
    add_cfg(REG_VECTOR_LENGTH, 13'd2);
    add_sample(16'hFC18, 16'h0000, FROM_PREDICTOR);
    // Length register at its top value, clamped, then cut short the same way.
    add_cfg(REG_VECTOR_LENGTH, 13'(LEN_REG_MAX));
    add_sample(16'h4000, 16'h0000, FROM_PREDICTOR);
    add_sample(16'hC000, 16'h0000, FROM_PREDICTOR);
    add_cfg(REG_VECTOR_LENGTH, 13'd1);
    add_sample(16'h2000, 16'h0000, FROM_PREDICTOR);
    // Three complex samples at the most negative corner.
    add_cfg(REG_VECTOR_LENGTH, 13'd3);
    add_cfg(REG_COMPLEX_MODE, 13'd1);
    add_sample(16'h8000, 16'h8000, FROM_PREDICTOR);
    add_sample(16'h8000, 16'h8000, FROM_PREDICTOR);
    add_sample(16'h8000, 16'h8000, 46340);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].addr, directed_rows[i].value);
      else
        send_sample(directed_rows[i].re, directed_rows[i].im, directed_rows[i].rms_typed);
    end

    // Random phases: a fresh setting, then mostly whole vectors with random
    // content. Some phases leave a vector unfinished so the next setting
    // lands mid-vector; very long lengths only ever get a partial vector.
    while (random_sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 15))
        0:                len = '0;
        1:                len = LEN_BITS'($urandom_range(EFF_MAX + 1, LEN_REG_MAX));
        2:                len = LEN_BITS'(EFF_MAX);
        3, 4, 5, 6, 7:    len = LEN_BITS'($urandom_range(1, 4));
        8, 9, 10:         len = LEN_BITS'($urandom_range(5, 16));
        default:          len = LEN_BITS'($urandom_range(17, 64));
      endcase
      write_reg(REG_VECTOR_LENGTH, len);
      // Only bit 0 selects the mode; toggle the rest of the word as well.
      write_reg(REG_COMPLEX_MODE, CFG_DATA_BITS'($urandom_range(0, LEN_REG_MAX)));
      eff = effective_length(len);
      if (eff <= 64) begin
        count = eff * $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) count += $urandom_range(0, eff - 1);
      end else begin
        count = $urandom_range(1, 20);
      end
      // Keep the random part within its sample budget.
      if (count > RANDOM_SAMPLES - random_sent) count = RANDOM_SAMPLES - random_sent;
      repeat (count) begin
        send_sample(pick_sample(), pick_sample(), FROM_PREDICTOR);
        random_sent++;
        // Now and then hold the sender until the block has drained.
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    // Close any open vector, then one complex vector near full scale.
    write_reg(REG_VECTOR_LENGTH, 13'd1);
    send_sample(pick_sample(), pick_sample(), FROM_PREDICTOR);
    write_reg(REG_VECTOR_LENGTH, 13'(FINAL_LEN));
    write_reg(REG_COMPLEX_MODE, 13'd1);
    repeat (FINAL_LEN) begin
      if ($urandom_range(0, 15) == 0)
        send_sample(pick_sample(), pick_sample(), FROM_PREDICTOR);
      else
        send_sample(16'h8000, 16'h8000, FROM_PREDICTOR);
    end

    // Wait out every expected result plus the back-end latency.
    drain_results();

    $display("Covered %0d samples, %0d results and %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("real and complex, lengths 0 through %0d, receiver stalls on.", LEN_REG_MAX);
    if (errors == 0 && rms_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, rms_expected_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
